// ===== design/audio_sample_ring_with_level_meter_unit_macros.svh =====
// Assertion macros shared by the audio ring and level meter modules.
`ifndef AUDIO_SAMPLE_RING_WITH_LEVEL_METER_UNIT_MACROS_SVH
`define AUDIO_SAMPLE_RING_WITH_LEVEL_METER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define ASRLM_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define ASRLM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/asrlm_pkg.sv =====
// Shared types, codes and constants of the audio ring and level meter.
`timescale 1ns / 1ps

package asrlm_pkg;

    localparam int RING_DEPTH_DEF   = 4096;
    localparam int MAX_READ_RUN_DEF = 64;

    localparam int SAMPLE_W     = 16;
    localparam int COUNT_W      = 32;
    localparam int SUM_W        = 63;
    localparam int READ_COUNT_W = 7;
    localparam int ROOT_W       = 16;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // Command queue between the front and the back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Command codes on the input channel.
    localparam logic [1:0] CMD_PUSH  = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_QUERY = 2'd2;
    localparam logic [1:0] CMD_CLEAR = 2'd3;

    // Result kinds on the output channel.
    localparam logic [1:0] KIND_SAMPLE = 2'd0;
    localparam logic [1:0] KIND_EMPTY  = 2'd1;
    localparam logic [1:0] KIND_STATS  = 2'd2;

    typedef enum logic [1:0] {
        OP_PUSH,
        OP_READ,
        OP_QUERY,
        OP_CLEAR
    } op_t;

    typedef struct packed {
        op_t                     op;
        logic [SAMPLE_W-1:0]     sample;
        logic [READ_COUNT_W-1:0] length;
    } queue_entry_t;

endpackage

// ===== design/asrlm_front.sv =====
// Front end: accepts items, holds the capture enable, classifies commands.
`timescale 1ns / 1ps

module asrlm_front
    import asrlm_pkg::*;
#(
    parameter int MAX_READ_RUN = MAX_READ_RUN_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic                    cfg_data,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [1:0]              command,
    input  logic [SAMPLE_W-1:0]     sample_in,
    input  logic [READ_COUNT_W-1:0] read_count,
    output logic                    push_valid,
    input  logic                    push_ready,
    output queue_entry_t            push_entry
);

    localparam logic [READ_COUNT_W-1:0] RUN_LIMIT = READ_COUNT_W'(MAX_READ_RUN);

    logic capture_reg;
    logic drop_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capture_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            capture_reg <= cfg_data;
        end
    end

    assign cfg_ready = 1'b1;
    assign in_ready  = push_ready;

    always_comb
    begin
        push_entry.sample = sample_in;
        push_entry.length = (read_count > RUN_LIMIT) ? RUN_LIMIT : read_count;
        case (command)
            CMD_PUSH:  push_entry.op = OP_PUSH;
            CMD_READ:  push_entry.op = OP_READ;
            CMD_QUERY: push_entry.op = OP_QUERY;
            CMD_CLEAR: push_entry.op = OP_CLEAR;
            default:   push_entry.op = OP_CLEAR;
        endcase
    end

    // A push while capture is off is taken and then forgotten.
    assign drop_item  = (command == CMD_PUSH) && !capture_reg;
    assign push_valid = in_valid && push_ready && !drop_item;

endmodule

// ===== design/asrlm_queue.sv =====
// Short command queue between the front end and the back end.
`timescale 1ns / 1ps

`include "audio_sample_ring_with_level_meter_unit_macros.svh"

module asrlm_queue
    import asrlm_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push_valid,
    output logic         push_ready,
    input  queue_entry_t push_entry,
    output logic         pop_valid,
    input  logic         pop,
    output queue_entry_t pop_entry
);

    queue_entry_t        entries_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   head_reg;
    logic [QPTR_W-1:0]   tail_reg;
    logic [QCNT_W-1:0]   count_reg;

    function automatic logic [QPTR_W-1:0] wrap_inc(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push_valid)
            begin
                tail_reg <= wrap_inc(tail_reg);
            end
            if (pop)
            begin
                head_reg <= wrap_inc(head_reg);
            end
            if (push_valid && !pop)
            begin
                count_reg <= count_reg + QCNT_W'(1);
            end
            else if (pop && !push_valid)
            begin
                count_reg <= count_reg - QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_valid)
        begin
            entries_reg[tail_reg] <= push_entry;
        end
    end

    assign push_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_entry  = entries_reg[head_reg];

    `ASRLM_ASSERT_IMPLY(a_queue_no_overflow, push_valid, count_reg != QCNT_W'(QUEUE_DEPTH), "command queue written while full")
    `ASRLM_ASSERT_NEXT(a_queue_count_up, push_valid && !pop, count_reg == $past(count_reg) + QCNT_W'(1), "command queue count did not follow a lone write")

endmodule

// ===== design/asrlm_divsqrt.sv =====
// Bit-serial divider followed by a bit-serial integer square root.
`timescale 1ns / 1ps

`include "audio_sample_ring_with_level_meter_unit_macros.svh"

module asrlm_divsqrt
    import asrlm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [SUM_W-1:0]   dividend,
    input  logic [COUNT_W-1:0] divisor,
    output logic               done,
    output logic [ROOT_W-1:0]  root
);

    typedef enum logic [1:0] {
        U_IDLE,
        U_DIV,
        U_SQRT
    } unit_state_t;

    unit_state_t          state_reg;
    logic [5:0]           step_reg;
    logic                 done_reg;
    logic [63:0]          q_reg;
    logic [COUNT_W-1:0]   divisor_reg;
    logic [COUNT_W-1:0]   rem_reg;
    logic [33:0]          srem_reg;
    logic [31:0]          root_reg;

    logic [COUNT_W:0]     div_shift;
    logic                 div_ge;
    logic [COUNT_W:0]     div_rem;
    logic [35:0]          sq_shift;
    logic [35:0]          sq_trial;
    logic                 sq_ge;
    logic [35:0]          sq_rem;

    // One quotient bit per cycle, restoring form.
    assign div_shift = {rem_reg, q_reg[63]};
    assign div_ge    = (div_shift >= {1'b0, divisor_reg});
    assign div_rem   = div_ge ? (div_shift - {1'b0, divisor_reg}) : div_shift;

    // One root bit per cycle, two radicand bits brought down each time.
    assign sq_shift = {srem_reg, q_reg[63:62]};
    assign sq_trial = {2'b00, root_reg, 2'b01};
    assign sq_ge    = (sq_shift >= sq_trial);
    assign sq_rem   = sq_ge ? (sq_shift - sq_trial) : sq_shift;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= U_IDLE;
            step_reg    <= '0;
            done_reg    <= 1'b0;
            q_reg       <= '0;
            divisor_reg <= '0;
            rem_reg     <= '0;
            srem_reg    <= '0;
            root_reg    <= '0;
        end
        else
        begin
            // The root is complete after the last square root step.
            done_reg <= (state_reg == U_SQRT) && (step_reg == '0);
            case (state_reg)
                U_IDLE:
                begin
                    if (start)
                    begin
                        q_reg       <= {1'b0, dividend};
                        divisor_reg <= divisor;
                        rem_reg     <= '0;
                        step_reg    <= 6'd63;
                        state_reg   <= U_DIV;
                    end
                end
                U_DIV:
                begin
                    rem_reg <= div_rem[COUNT_W-1:0];
                    q_reg   <= {q_reg[62:0], div_ge};
                    if (step_reg == '0)
                    begin
                        srem_reg  <= '0;
                        root_reg  <= '0;
                        step_reg  <= 6'd31;
                        state_reg <= U_SQRT;
                    end
                    else
                    begin
                        step_reg <= step_reg - 6'd1;
                    end
                end
                U_SQRT:
                begin
                    srem_reg <= sq_rem[33:0];
                    root_reg <= {root_reg[30:0], sq_ge};
                    q_reg    <= {q_reg[61:0], 2'b00};
                    step_reg <= step_reg - 6'd1;
                    if (step_reg == '0)
                    begin
                        state_reg <= U_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= U_IDLE;
                end
            endcase
        end
    end

    assign done = done_reg;
    assign root = root_reg[ROOT_W-1:0];

    `ASRLM_ASSERT_IMPLY(a_unit_start_idle, start, state_reg == U_IDLE, "root unit started while busy")

endmodule

// ===== design/asrlm_back.sv =====
// Back end: sample ring, statistics, read runs, reports and the output register.
`timescale 1ns / 1ps

`include "audio_sample_ring_with_level_meter_unit_macros.svh"

module asrlm_back
    import asrlm_pkg::*;
#(
    parameter int RING_DEPTH = RING_DEPTH_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       q_valid,
    output logic                       q_pop,
    input  queue_entry_t               q_entry,
    output logic                       ds_start,
    output logic [SUM_W-1:0]           ds_dividend,
    output logic [COUNT_W-1:0]         ds_divisor,
    input  logic                       ds_done,
    input  logic [ROOT_W-1:0]          ds_root,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [1:0]                 result_kind,
    output logic signed [SAMPLE_W-1:0] sample_out,
    output logic                       last_of_run,
    output logic [COUNT_W-1:0]         sample_count,
    output logic [SAMPLE_W-1:0]        peak_level,
    output logic [ROOT_W-1:0]          rms_level
);

    localparam int PTR_W = $clog2(RING_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ACCUM,
        S_RD_ISSUE,
        S_RD_WAIT,
        S_EMPTY,
        S_CALC,
        S_REPORT
    } back_state_t;

    back_state_t              state_reg;
    logic [SAMPLE_W-1:0]      ring_mem [RING_DEPTH];
    logic [SAMPLE_W-1:0]      rd_data_reg;
    logic [PTR_W-1:0]         wr_ptr_reg;
    logic [PTR_W-1:0]         rd_ptr_reg;
    logic [COUNT_W-1:0]       count_reg;
    logic [SAMPLE_W-1:0]      peak_reg;
    logic [SUM_W-1:0]         sum_reg;
    logic [31:0]              sq_reg;
    logic [READ_COUNT_W-1:0]  len_rem_reg;
    logic                     last_reg;
    logic [ROOT_W-1:0]        rms_hold_reg;

    logic                     out_valid_reg;
    logic [1:0]               out_kind_reg;
    logic [SAMPLE_W-1:0]      out_sample_reg;
    logic                     out_last_reg;
    logic [COUNT_W-1:0]       out_count_reg;
    logic [SAMPLE_W-1:0]      out_peak_reg;
    logic [ROOT_W-1:0]        out_rms_reg;

    logic                     slot_free;
    logic                     out_load;
    logic                     mem_we;
    logic                     mem_re;
    logic [SAMPLE_W-1:0]      mag;
    logic [31:0]              mag_sq;
    logic [PTR_W-1:0]         wr_ptr_inc;
    logic [PTR_W-1:0]         rd_ptr_inc;
    logic                     rd_last;

    function automatic logic [PTR_W-1:0] ring_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(RING_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign slot_free  = !out_valid_reg || out_ready;
    assign out_load   = slot_free && (state_reg inside {S_RD_WAIT, S_EMPTY, S_REPORT});
    assign q_pop      = (state_reg == S_IDLE) && q_valid;
    assign mem_we     = q_pop && (q_entry.op == OP_PUSH);
    assign mem_re     = (state_reg == S_RD_ISSUE);
    assign wr_ptr_inc = ring_inc(wr_ptr_reg);
    assign rd_ptr_inc = ring_inc(rd_ptr_reg);

    // The most negative sample has magnitude 0x8000, which still fits 16 bits.
    assign mag    = q_entry.sample[SAMPLE_W-1] ? (~q_entry.sample + SAMPLE_W'(1))
                                               : q_entry.sample;
    assign mag_sq = {16'd0, mag} * {16'd0, mag};

    // The write pointer is still during a run, so the last sample is known at issue.
    assign rd_last = (len_rem_reg == READ_COUNT_W'(1)) || (rd_ptr_inc == wr_ptr_reg);

    assign ds_start    = q_pop && (q_entry.op == OP_QUERY) && (count_reg != '0);
    assign ds_dividend = sum_reg;
    assign ds_divisor  = count_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            ring_mem[wr_ptr_reg] <= q_entry.sample;
        end
        if (mem_re)
        begin
            rd_data_reg <= ring_mem[rd_ptr_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            count_reg      <= '0;
            peak_reg       <= '0;
            sum_reg        <= '0;
            sq_reg         <= '0;
            len_rem_reg    <= '0;
            last_reg       <= 1'b0;
            rms_hold_reg   <= '0;
            out_valid_reg  <= 1'b0;
            out_kind_reg   <= KIND_SAMPLE;
            out_sample_reg <= '0;
            out_last_reg   <= 1'b0;
            out_count_reg  <= '0;
            out_peak_reg   <= '0;
            out_rms_reg    <= '0;
        end
        else
        begin
            out_valid_reg <= out_load || (out_valid_reg && !out_ready);
            case (state_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        case (q_entry.op)
                            OP_PUSH:
                            begin
                                wr_ptr_reg <= wr_ptr_inc;
                                // Once the count saturates the statistics freeze.
                                if (count_reg != COUNT_MAX)
                                begin
                                    count_reg <= count_reg + COUNT_W'(1);
                                    if (mag > peak_reg)
                                    begin
                                        peak_reg <= mag;
                                    end
                                    sq_reg    <= mag_sq;
                                    state_reg <= S_ACCUM;
                                end
                            end
                            OP_READ:
                            begin
                                len_rem_reg <= q_entry.length;
                                if ((q_entry.length == '0) || (rd_ptr_reg == wr_ptr_reg))
                                begin
                                    state_reg <= S_EMPTY;
                                end
                                else
                                begin
                                    state_reg <= S_RD_ISSUE;
                                end
                            end
                            OP_QUERY:
                            begin
                                if (count_reg == '0)
                                begin
                                    rms_hold_reg <= '0;
                                    state_reg    <= S_REPORT;
                                end
                                else
                                begin
                                    state_reg <= S_CALC;
                                end
                            end
                            OP_CLEAR:
                            begin
                                count_reg <= '0;
                                peak_reg  <= '0;
                                sum_reg   <= '0;
                            end
                            default:
                            begin
                                state_reg <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_ACCUM:
                begin
                    sum_reg   <= sum_reg + SUM_W'(sq_reg);
                    state_reg <= S_IDLE;
                end
                S_RD_ISSUE:
                begin
                    last_reg    <= rd_last;
                    rd_ptr_reg  <= rd_ptr_inc;
                    len_rem_reg <= len_rem_reg - READ_COUNT_W'(1);
                    state_reg   <= S_RD_WAIT;
                end
                S_RD_WAIT:
                begin
                    if (slot_free)
                    begin
                        out_kind_reg   <= KIND_SAMPLE;
                        out_sample_reg <= rd_data_reg;
                        out_last_reg   <= last_reg;
                        out_count_reg  <= '0;
                        out_peak_reg   <= '0;
                        out_rms_reg    <= '0;
                        state_reg      <= last_reg ? S_IDLE : S_RD_ISSUE;
                    end
                end
                S_EMPTY:
                begin
                    if (slot_free)
                    begin
                        out_kind_reg   <= KIND_EMPTY;
                        out_sample_reg <= '0;
                        out_last_reg   <= 1'b1;
                        out_count_reg  <= '0;
                        out_peak_reg   <= '0;
                        out_rms_reg    <= '0;
                        state_reg      <= S_IDLE;
                    end
                end
                S_CALC:
                begin
                    if (ds_done)
                    begin
                        rms_hold_reg <= ds_root;
                        state_reg    <= S_REPORT;
                    end
                end
                S_REPORT:
                begin
                    if (slot_free)
                    begin
                        out_kind_reg   <= KIND_STATS;
                        out_sample_reg <= '0;
                        out_last_reg   <= 1'b1;
                        out_count_reg  <= count_reg;
                        out_peak_reg   <= peak_reg;
                        out_rms_reg    <= rms_hold_reg;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid    = out_valid_reg;
    assign result_kind  = out_kind_reg;
    assign sample_out   = $signed(out_sample_reg);
    assign last_of_run  = out_last_reg;
    assign sample_count = out_count_reg;
    assign peak_level   = out_peak_reg;
    assign rms_level    = out_rms_reg;

    `ASRLM_ASSERT_IMPLY(a_read_not_past_write, state_reg == S_RD_ISSUE, rd_ptr_reg != wr_ptr_reg, "ring read issued at the write pointer")
    `ASRLM_ASSERT_IMPLY(a_read_run_budget, state_reg == S_RD_ISSUE, len_rem_reg != '0, "ring read issued with no run budget left")

endmodule

// ===== design/audio_sample_ring_with_level_meter_unit.sv =====
// Top level of the audio sample ring with peak and RMS level meter.
//
//  Channel  | Handshake             | Payload
//  ---------+-----------------------+--------------------------------------------------
//  config   | cfg_valid / cfg_ready | cfg_data (capture enable)
//  input    | in_valid / in_ready   | command, sample_in, read_count
//  output   | out_valid / out_ready | result_kind, sample_out, last_of_run,
//           |                       | sample_count, peak_level, rms_level
//
// The front takes one item per cycle into a four-entry command queue until it fills.
// The back runs one command at a time: a push adds an accumulate state while the count
// still moves; a read issues each sample to the registered ring port, then loads it out;
// a query waits on the 64-step divider and the 32-step square root.
// Reset is asynchronous and needs no sweep, since ring entries are valid once written.
// A stalled output stops the back at its next result; the queue still takes items.
`timescale 1ns / 1ps

module audio_sample_ring_with_level_meter_unit
    import asrlm_pkg::*;
#(
    parameter int RING_DEPTH   = RING_DEPTH_DEF,
    parameter int MAX_READ_RUN = MAX_READ_RUN_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic                       cfg_data,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [1:0]                 command,
    input  logic signed [SAMPLE_W-1:0] sample_in,
    input  logic [READ_COUNT_W-1:0]    read_count,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [1:0]                 result_kind,
    output logic signed [SAMPLE_W-1:0] sample_out,
    output logic                       last_of_run,
    output logic [COUNT_W-1:0]         sample_count,
    output logic [SAMPLE_W-1:0]        peak_level,
    output logic [ROOT_W-1:0]          rms_level
);

    logic               push_valid;
    logic               push_ready;
    queue_entry_t       push_entry;
    logic               q_valid;
    logic               q_pop;
    queue_entry_t       q_entry;
    logic               ds_start;
    logic [SUM_W-1:0]   ds_dividend;
    logic [COUNT_W-1:0] ds_divisor;
    logic               ds_done;
    logic [ROOT_W-1:0]  ds_root;

    asrlm_front #(
        .MAX_READ_RUN (MAX_READ_RUN)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .command    (command),
        .sample_in  (sample_in),
        .read_count (read_count),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry)
    );

    asrlm_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .pop_valid  (q_valid),
        .pop        (q_pop),
        .pop_entry  (q_entry)
    );

    asrlm_divsqrt u_divsqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (ds_start),
        .dividend (ds_dividend),
        .divisor  (ds_divisor),
        .done     (ds_done),
        .root     (ds_root)
    );

    asrlm_back #(
        .RING_DEPTH (RING_DEPTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_pop        (q_pop),
        .q_entry      (q_entry),
        .ds_start     (ds_start),
        .ds_dividend  (ds_dividend),
        .ds_divisor   (ds_divisor),
        .ds_done      (ds_done),
        .ds_root      (ds_root),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .result_kind  (result_kind),
        .sample_out   (sample_out),
        .last_of_run  (last_of_run),
        .sample_count (sample_count),
        .peak_level   (peak_level),
        .rms_level    (rms_level)
    );

endmodule

// ===== test/tb_audio_sample_ring_with_level_meter_unit.sv =====
// Self-checking testbench for the audio sample ring with peak and RMS level meter.
`timescale 1ns / 1ps

module tb_audio_sample_ring_with_level_meter_unit;
    import asrlm_pkg::*;

    localparam int PTR_W        = $clog2(RING_DEPTH_DEF);
    localparam int SETTLE       = 40;
    localparam int LONG_HOLD    = 300;
    localparam int MAX_PRINTED  = 100;
    localparam int ITEM_TARGET  = 120;

    typedef struct packed {
        logic [1:0]          kind;
        logic [SAMPLE_W-1:0] sample;
        logic                last;
        logic [COUNT_W-1:0]  total;
        logic [SAMPLE_W-1:0] peak;
        logic [ROOT_W-1:0]   rms;
    } meter_result_t;

    class ring_meter_scoreboard;
        logic [SAMPLE_W-1:0] ring [RING_DEPTH_DEF];
        logic [PTR_W-1:0]    wr_ptr;
        logic [PTR_W-1:0]    rd_ptr;
        logic [COUNT_W-1:0]  total;
        logic [SAMPLE_W-1:0] peak;
        logic [SUM_W-1:0]    sum_sq;
        bit                  capture_on;
        meter_result_t       due_results [$];
        int                  mismatches;
        int                  checked;

        function new();
            wr_ptr     = '0;
            rd_ptr     = '0;
            total      = '0;
            peak       = '0;
            sum_sq     = '0;
            capture_on = 1'b0;
            mismatches = 0;
            checked    = 0;
        endfunction

        function void set_capture(bit en);
            capture_on = en;
        endfunction

        function int pending();
            return due_results.size();
        endfunction

        function int unread();
            logic [PTR_W-1:0] avail;
            avail = wr_ptr - rd_ptr;
            return int'(avail);
        endfunction

        // Bit-by-bit integer square root; the mean of squares stays below 2^62.
        function logic [ROOT_W-1:0] root_of(logic [SUM_W-1:0] v);
            logic [31:0] acc;
            logic [31:0] trial;
            int          b;
            acc = '0;
            for (b = 31; b >= 0; b--) begin
                trial = acc | (32'd1 << b);
                if (64'(trial) * 64'(trial) <= 64'(v))
                    acc = trial;
            end
            return acc[ROOT_W-1:0];
        endfunction

        function void note_item(logic [1:0] cmd, logic [SAMPLE_W-1:0] smp,
                                logic [READ_COUNT_W-1:0] len);
            meter_result_t    r;
            logic [16:0]      mag;
            logic [PTR_W-1:0] avail;
            int               take;
            int               i;
            r = '0;
            case (cmd)
                CMD_PUSH: begin
                    if (capture_on) begin
                        mag = smp[SAMPLE_W-1] ? (17'h10000 - {1'b0, smp}) : {1'b0, smp};
                        ring[wr_ptr] = smp;
                        wr_ptr = wr_ptr + 1'b1;
                        // A saturated count freezes all statistics.
                        if (total != COUNT_MAX) begin
                            total = total + 1'b1;
                            if (mag > {1'b0, peak})
                                peak = mag[SAMPLE_W-1:0];
                            sum_sq = sum_sq + SUM_W'(mag) * SUM_W'(mag);
                        end
                    end
                end
                CMD_READ: begin
                    avail = wr_ptr - rd_ptr;
                    take  = (int'(len) > MAX_READ_RUN_DEF) ? MAX_READ_RUN_DEF : int'(len);
                    if (int'(avail) < take)
                        take = int'(avail);
                    if (take == 0) begin
                        r.kind = KIND_EMPTY;
                        r.last = 1'b1;
                        due_results.push_back(r);
                    end else begin
                        for (i = 0; i < take; i++) begin
                            r.kind   = KIND_SAMPLE;
                            r.sample = ring[rd_ptr];
                            r.last   = (i == take - 1);
                            rd_ptr   = rd_ptr + 1'b1;
                            due_results.push_back(r);
                        end
                    end
                end
                CMD_QUERY: begin
                    r.kind  = KIND_STATS;
                    r.last  = 1'b1;
                    r.total = total;
                    r.peak  = peak;
                    r.rms   = (total == '0) ? '0 : root_of(sum_sq / SUM_W'(total));
                    due_results.push_back(r);
                end
                default: begin
                    total  = '0;
                    peak   = '0;
                    sum_sq = '0;
                end
            endcase
        endfunction

        task report(string msg);
            mismatches++;
            if (mismatches <= MAX_PRINTED)
                $display("mismatch: %s", msg);
        endtask

        task check_result(meter_result_t got);
            meter_result_t want;
            if (due_results.size() == 0) begin
                report($sformatf("result %0d arrived with nothing expected (kind %0d)",
                                 checked, got.kind));
            end else begin
                want = due_results.pop_front();
                if (got.kind !== want.kind)
                    report($sformatf("result %0d kind %0d, expected %0d",
                                     checked, got.kind, want.kind));
                if (got.sample !== want.sample)
                    report($sformatf("result %0d sample %0d, expected %0d",
                                     checked, $signed(got.sample), $signed(want.sample)));
                if (got.last !== want.last)
                    report($sformatf("result %0d last %0b, expected %0b",
                                     checked, got.last, want.last));
                if (got.total !== want.total)
                    report($sformatf("result %0d count %0d, expected %0d",
                                     checked, got.total, want.total));
                if (got.peak !== want.peak)
                    report($sformatf("result %0d peak %0d, expected %0d",
                                     checked, got.peak, want.peak));
                if (got.rms !== want.rms)
                    report($sformatf("result %0d rms %0d, expected %0d",
                                     checked, got.rms, want.rms));
            end
            checked++;
        endtask

        task check_leftover();
            if (due_results.size() != 0)
                report($sformatf("%0d expected results never arrived", due_results.size()));
        endtask
    endclass

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic                       cfg_data = 1'b0;
    logic                       in_valid = 1'b0;
    logic                       in_ready;
    logic [1:0]                 command = CMD_PUSH;
    logic signed [SAMPLE_W-1:0] sample_in = '0;
    logic [READ_COUNT_W-1:0]    read_count = '0;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    logic [1:0]                 result_kind;
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       last_of_run;
    logic [COUNT_W-1:0]         sample_count;
    logic [SAMPLE_W-1:0]        peak_level;
    logic [ROOT_W-1:0]          rms_level;

    ring_meter_scoreboard sb = new();

    bit calm = 1'b0;
    bit steady = 1'b0;
    bit hold_pending = 1'b0;
    bit holding = 1'b0;
    int items_taken = 0;

    audio_sample_ring_with_level_meter_unit i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .command      (command),
        .sample_in    (sample_in),
        .read_count   (read_count),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .result_kind  (result_kind),
        .sample_out   (sample_out),
        .last_of_run  (last_of_run),
        .sample_count (sample_count),
        .peak_level   (peak_level),
        .rms_level    (rms_level)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin : result_monitor
        meter_result_t got;
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) begin
            got.kind   = result_kind;
            got.sample = sample_out;
            got.last   = last_of_run;
            got.total  = sample_count;
            got.peak   = peak_level;
            got.rms    = rms_level;
            sb.check_result(got);
        end
    end

    // The receiver stalls in bursts, and once holds off long enough for the queue to fill.
    initial
    begin : receiver
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            if (calm) begin
                out_ready <= 1'b1;
                @(posedge clk);
            end else if (hold_pending) begin
                out_ready <= 1'b0;
                holding = 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                holding = 1'b0;
                hold_pending = 1'b0;
            end else if ($urandom_range(0, 2) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge clk);
            end else begin
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 30)) @(posedge clk);
            end
        end
    end

    task automatic maybe_idle();
        if (!calm && !steady && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
    endtask

    // Valid stays high between back-to-back items; only idling lowers it.
    task automatic send_item(logic [1:0] cmd, logic [SAMPLE_W-1:0] smp,
                             logic [READ_COUNT_W-1:0] len);
        maybe_idle();
        in_valid   <= 1'b1;
        command    <= cmd;
        sample_in  <= smp;
        read_count <= len;
        @(posedge clk);
        while (in_ready !== 1'b1) @(posedge clk);
        items_taken++;
        sb.note_item(cmd, smp, len);
    endtask

    // Pushes and clears leave no result, so a settle wait follows the last expected result.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_capture(bit en);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= en;
        @(posedge clk);
        while (cfg_ready !== 1'b1) @(posedge clk);
        sb.set_capture(en);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 11))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [READ_COUNT_W-1:0] pick_length();
        if ($urandom_range(0, 3) == 0)
            return 7'($urandom_range(0, 127));
        return 7'($urandom_range(1, MAX_READ_RUN_DEF));
    endfunction

    // Mostly runs of pushes drained by reads, with queries and clears mixed in.
    task automatic random_segment();
        int pick;
        int burst;
        int i;
        steady = ($urandom_range(0, 2) == 0);
        pick   = $urandom_range(0, 9);
        if (pick < 5) begin
            burst = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 30) : $urandom_range(1, 12);
            for (i = 0; i < burst; i++)
                send_item(CMD_PUSH, pick_sample(), 7'($urandom));
            send_item(CMD_READ, 16'($urandom), pick_length());
        end else if (pick < 7) begin
            send_item(CMD_READ, 16'($urandom), pick_length());
        end else if (pick < 9) begin
            send_item(CMD_QUERY, 16'($urandom), 7'($urandom));
        end else begin
            send_item(CMD_CLEAR, 16'($urandom), 7'($urandom));
        end
    endtask

    initial
    begin : stimulus
        int i;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Capture is off after reset: empty statistics, empty ring, ignored push.
        send_item(CMD_QUERY, 16'd0, 7'd0);
        send_item(CMD_READ, 16'd0, 7'd5);
        send_item(CMD_PUSH, 16'd1234, 7'd0);
        send_item(CMD_READ, 16'd0, 7'd64);

        write_capture(1'b1);
        send_item(CMD_PUSH, 16'h7FFF, 7'd0);
        send_item(CMD_PUSH, 16'h8000, 7'd0);
        send_item(CMD_PUSH, 16'h0000, 7'd0);
        send_item(CMD_PUSH, 16'hFFFF, 7'd0);
        send_item(CMD_PUSH, 16'h0001, 7'd0);
        send_item(CMD_QUERY, 16'd0, 7'd0);
        send_item(CMD_READ, 16'd0, 7'd0);
        send_item(CMD_READ, 16'd0, 7'd2);
        send_item(CMD_READ, 16'd0, 7'd127);
        send_item(CMD_READ, 16'd0, 7'd64);
        send_item(CMD_CLEAR, 16'd0, 7'd0);
        send_item(CMD_QUERY, 16'd0, 7'd0);
        send_item(CMD_PUSH, 16'h8000, 7'd0);
        send_item(CMD_PUSH, 16'd100, 7'd0);
        send_item(CMD_QUERY, 16'hFFFF, 7'h7F);
        send_item(CMD_READ, 16'hFFFF, 7'd127);

        while (items_taken < 60)
            random_segment();

        // Keep offering items while the output is held off so the input stalls.
        in_valid <= 1'b0;
        hold_pending = 1'b1;
        while (!holding) @(posedge clk);
        steady = 1'b1;
        for (i = 0; i < 6; i++)
            send_item(CMD_PUSH, pick_sample(), 7'd0);
        send_item(CMD_READ, 16'd0, 7'd3);
        send_item(CMD_QUERY, 16'd0, 7'd0);
        send_item(CMD_QUERY, 16'd0, 7'd0);
        send_item(CMD_READ, 16'd0, 7'd127);
        send_item(CMD_QUERY, 16'd0, 7'd0);
        send_item(CMD_PUSH, pick_sample(), 7'd0);
        send_item(CMD_READ, 16'd0, 7'd64);

        write_capture(1'b0);
        while (items_taken < 95)
            random_segment();

        write_capture(1'b1);
        while (items_taken < ITEM_TARGET)
            random_segment();

        // Last part without idling: drain the ring, then a short run and a final report.
        wait_idle();
        calm = 1'b1;
        while (sb.unread() != 0)
            send_item(CMD_READ, 16'd0, 7'd64);
        send_item(CMD_READ, 16'd0, 7'd64);
        for (i = 0; i < 3; i++)
            send_item(CMD_PUSH, pick_sample(), 7'd0);
        send_item(CMD_READ, 16'd0, 7'd127);
        send_item(CMD_QUERY, 16'd0, 7'd0);

        wait_idle();
        sb.check_leftover();
        if (sb.mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin : watchdog
        #6000000;
        $display("FAIL");
        $finish;
    end

endmodule
